@@ hdl/depq_pkg.sv @@
// Shared types and constants for the double-ended priority queue.
package depq_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int COUNT_OUT_W = 7;

  typedef enum logic [1:0] {
    OP_INSERT     = 2'd0,
    OP_REMOVE_MAX = 2'd1,
    OP_REMOVE_MIN = 2'd2
  } op_t;

  // Command broadcast to every cell of the sorted chain.
  typedef struct packed {
    logic                     insert;
    logic                     remove_min;
    logic signed [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage

@@ hdl/depq_cell.sv @@
// One slot of the sorted register chain.
module depq_cell
  import depq_pkg::*;
(
  input  logic                     clk,
  input  cell_cmd_t                cmd,
  input  logic [CNT_W-1:0]         count,
  input  logic [IDX_W-1:0]         index,
  input  logic signed [DATA_W-1:0] left_data,
  input  logic                     left_lt,
  input  logic signed [DATA_W-1:0] right_data,
  output logic signed [DATA_W-1:0] data,
  output logic                     lt,
  output logic                     top
);

  logic [CNT_W-1:0]         slot;
  logic                     occupied;
  logic                     at_end;
  logic signed [DATA_W-1:0] data_next;

  assign slot     = CNT_W'(index);
  assign occupied = slot < count;
  assign at_end   = slot == count;

  // The new value belongs before this entry when it is strictly smaller.
  assign lt  = occupied && (cmd.value < data);
  assign top = count == (slot + CNT_W'(1));

  always_comb begin
    data_next = data;
    if (cmd.insert) begin
      if (left_lt) begin
        data_next = left_data;
      end else if (lt || at_end) begin
        data_next = cmd.value;
      end
    end else if (cmd.remove_min) begin
      data_next = right_data;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

@@ hdl/double_ended_priority_queue.sv @@
// Top level of the double-ended priority queue built on a sorted cell chain.
// The result of a command appears in the cycle after it is accepted.
// Throughput: one command per cycle; busy stays low, every cell updates at once.
// The chain is kept sorted ascending: the minimum sits in cell 0, the maximum in
// the cell just below the fill count, which is picked by a one-hot select.
// Synchronous active-high reset clears the fill count, the result strobe and the
// drop flag; cell contents are not reset and unused cells are never reported.
module double_ended_priority_queue
  import depq_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    operation,
  input  logic signed [DATA_W-1:0]      value,
  output logic                          done,
  output logic signed [DATA_W-1:0]      max_value,
  output logic signed [DATA_W-1:0]      min_value,
  output logic                          is_empty,
  output logic [COUNT_OUT_W-1:0]        entry_count,
  output logic                          dropped
);

  logic                     accept;
  logic                     full;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;
  logic                     drop_next;
  cell_cmd_t                cmd;
  logic signed [DATA_W-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0]      cell_lt;
  logic [CAPACITY-1:0]      cell_top;
  logic signed [DATA_W-1:0] top_data;

  // Every cell updates at the edge that takes a command, so the block never stalls.
  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = count == CNT_W'(CAPACITY);

  // Decode the command. A removal from an empty store and the unused code
  // leave the chain alone; an insert into a full store is only flagged.
  always_comb begin
    cmd.insert     = 1'b0;
    cmd.remove_min = 1'b0;
    cmd.value      = value;
    count_next     = count;
    drop_next      = 1'b0;
    if (accept) begin
      case (operation)
        OP_INSERT: begin
          if (full) begin
            drop_next = 1'b1;
          end else begin
            cmd.insert = 1'b1;
            count_next = count + CNT_W'(1);
          end
        end
        OP_REMOVE_MAX: begin
          if (count != '0) begin
            count_next = count - CNT_W'(1);
          end
        end
        OP_REMOVE_MIN: begin
          if (count != '0) begin
            cmd.remove_min = 1'b1;
            count_next     = count - CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // The chain: each cell sees its left neighbor for inserts (entries shift up
  // behind the insertion point) and its right neighbor for removing the minimum.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_data;
    logic                     left_lt;
    logic signed [DATA_W-1:0] right_data;

    if (i == 0) begin : g_first
      assign left_data = '0;
      assign left_lt   = 1'b0;
    end else begin : g_inner
      assign left_data = cell_data[i-1];
      assign left_lt   = cell_lt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_data = '0;
    end else begin : g_right
      assign right_data = cell_data[i+1];
    end

    depq_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .count      (count),
      .index      (IDX_W'(i)),
      .left_data  (left_data),
      .left_lt    (left_lt),
      .right_data (right_data),
      .data       (cell_data[i]),
      .lt         (cell_lt[i]),
      .top        (cell_top[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      done    <= 1'b0;
      dropped <= 1'b0;
    end else begin
      count   <= count_next;
      done    <= accept;
      dropped <= drop_next;
    end
  end

  // Exactly one cell flags itself as the top entry when the store is not empty.
  always_comb begin
    top_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (cell_top[i]) begin
        top_data = top_data | cell_data[i];
      end
    end
  end

  // The result beat is read straight from the updated chain and fill count.
  assign is_empty    = count == '0;
  assign max_value   = is_empty ? '0 : top_data;
  assign min_value   = is_empty ? '0 : cell_data[0];
  assign entry_count = COUNT_OUT_W'(count);

  // Every accepted command yields exactly one result beat in the next cycle.
  a_beat_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("accepted command produced no result beat");

  // The fill count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("fill count exceeds capacity");

  // A drop is only reported on a result beat, with the store still full.
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    dropped |-> (done && full))
    else $error("drop reported while store not full");

  // The chain stays sorted, so a non-empty store has min not above max.
  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    (done && !is_empty) |-> (min_value <= max_value))
    else $error("minimum above maximum");

  // Removing from a non-empty store shrinks the count by one.
  a_remove_count: assert property (@(posedge clk) disable iff (rst)
    (accept && count != '0 &&
     (operation == OP_REMOVE_MAX || operation == OP_REMOVE_MIN))
    |=> (count == $past(count) - CNT_W'(1)))
    else $error("removal did not decrement the count");

endmodule

@@ dv/double_ended_priority_queue_tb.sv @@
// Self-checking testbench for the double-ended priority queue: directed table, then random runs.
`timescale 1ns / 100ps

module double_ended_priority_queue_tb;
  import depq_pkg::*;

  // The operation port is two bits wide. The package names three codes, and
  // the fourth code has to be ignored by the block.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Stop the run here no matter what.
  localparam int CYCLE_LIMIT = 200000;

  // Cycles to keep watching after the last expected beat, so that a stray
  // strobe from the registered result stage is still caught.
  localparam int DRAIN_CYCLES = 8;

  localparam int MAX_SHOWN = 10;
  localparam int RUN_LEN   = 40;
  localparam int RUN_COUNT = 10;

  // One result beat, with the same fields as the result ports.
  typedef struct {
    logic signed [DATA_W-1:0] max_v;
    logic signed [DATA_W-1:0] min_v;
    logic                     empty;
    logic [COUNT_OUT_W-1:0]   count;
    logic                     drop;
  } queue_report_t;

  // One row of the directed table. Where typed is set, the row carries its
  // own expected beat. Other rows are checked against the shadow queue.
  typedef struct {
    logic [1:0]               code;
    logic signed [DATA_W-1:0] operand;
    logic                     typed;
    queue_report_t            report;
  } directed_row_t;

  // The random part is a sequence of runs. Each kind leans the operation
  // mix a different way, so that the store both fills past capacity and
  // drains to empty.
  typedef enum int {MIX_RUN, FILL_RUN, DRAIN_RUN} run_kind_t;

  localparam int DIRECTED_ROWS = 20;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic [1:0] operation;
  logic signed [DATA_W-1:0] value;
  logic done;
  logic signed [DATA_W-1:0] max_value;
  logic signed [DATA_W-1:0] min_value;
  logic is_empty;
  logic [COUNT_OUT_W-1:0] entry_count;
  logic dropped;

  // The predictor's copy of the store, kept sorted ascending in signed order.
  logic signed [DATA_W-1:0] shadow_store[$];

  // Beats that have been predicted but not seen yet, oldest first.
  queue_report_t awaited_reports[$];

  int fail_count  = 0;
  int cycle_count = 0;
  int idle_pct    = 0;

  double_ended_priority_queue uut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .operation   (operation),
    .value       (value),
    .done        (done),
    .max_value   (max_value),
    .min_value   (min_value),
    .is_empty    (is_empty),
    .entry_count (entry_count),
    .dropped     (dropped)
  );

  always #6 clk = ~clk;

  // Applies one command to the shadow store and returns the beat that the
  // block must report for it. Duplicates are kept. A new value goes after
  // every entry that is not larger than it. A removal on an empty store and
  // the unused code leave the store alone. An insert into a full store is
  // refused and flagged.
  function automatic queue_report_t apply_to_shadow(logic [1:0] code,
                                                    logic signed [DATA_W-1:0] operand);
    queue_report_t rep;
    int pos;
    rep.drop = 1'b0;
    case (code)
      OP_INSERT: begin
        if (shadow_store.size() >= CAPACITY) begin
          rep.drop = 1'b1;
        end else begin
          pos = 0;
          while (pos < shadow_store.size() && !(operand < shadow_store[pos])) pos++;
          shadow_store.insert(pos, operand);
        end
      end
      OP_REMOVE_MAX: begin
        if (shadow_store.size() > 0) void'(shadow_store.pop_back());
      end
      OP_REMOVE_MIN: begin
        if (shadow_store.size() > 0) void'(shadow_store.pop_front());
      end
      default: ;
    endcase
    rep.count = COUNT_OUT_W'(shadow_store.size());
    if (shadow_store.size() == 0) begin
      rep.max_v = '0;
      rep.min_v = '0;
      rep.empty = 1'b1;
    end else begin
      rep.max_v = shadow_store[$];
      rep.min_v = shadow_store[0];
      rep.empty = 1'b0;
    end
    return rep;
  endfunction

  // Random operand. Full 32-bit values exercise every bit. The narrow band
  // around zero produces many duplicates, and the two extremes test the
  // signed ordering at the edges of the range.
  function automatic logic signed [DATA_W-1:0] pick_operand();
    case ($urandom_range(9))
      4, 5, 6: return $signed(DATA_W'($urandom_range(8))) - 4;
      7:       return 32'sh7fffffff;
      8:       return 32'sh80000000;
      default: return $signed($urandom());
    endcase
  endfunction

  // Random operation code, weighted by the percentage of inserts. A few
  // percent use the unused code. Removals split evenly between the two ends.
  function automatic logic [1:0] pick_code(int insert_pct);
    int roll;
    roll = $urandom_range(99);
    if (roll < 3) return OP_UNUSED;
    if (roll < 3 + insert_pct) return OP_INSERT;
    return $urandom_range(1) ? OP_REMOVE_MAX : OP_REMOVE_MIN;
  endfunction

  // Sends one command beat. The sender first idles for a random number of
  // cycles. Each cycle is idle with probability idle_pct. The task then
  // raises start at a falling edge and holds it until a rising edge sees
  // busy low. At that edge the beat is accepted, and the expected result is
  // queued at once. Start stays high at the next falling edge whenever the
  // next command follows without a gap. Each falling edge therefore assigns
  // start only once.
  task automatic issue_command(logic [1:0] code, logic signed [DATA_W-1:0] operand,
                               logic typed, queue_report_t typed_report);
    queue_report_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start     <= 1'b1;
    operation <= code;
    value     <= operand;
    do @(posedge clk); while (busy);
    // The shadow store must follow every beat, even when the table supplies
    // the expected result itself.
    predicted = apply_to_shadow(code, operand);
    awaited_reports.insert(awaited_reports.size(), typed ? typed_report : predicted);
  endtask

  // Result checker. A strobe is sampled at the rising edge that closes its
  // cycle and is matched against the oldest expectation. A strobe with
  // nothing awaited is a failure. Because the block registers its result, the
  // matching expectation was queued at an earlier edge.
  always @(posedge clk) begin
    queue_report_t exp_rep;
    if (!rst && done) begin
      if (awaited_reports.size() == 0) begin
        if (fail_count < MAX_SHOWN)
          $display("unexpected result beat: max=%h min=%h empty=%b count=%0d dropped=%b",
                   max_value, min_value, is_empty, entry_count, dropped);
        fail_count++;
      end else begin
        exp_rep = awaited_reports.pop_front();
        if (max_value !== exp_rep.max_v || min_value !== exp_rep.min_v ||
            is_empty !== exp_rep.empty || entry_count !== exp_rep.count ||
            dropped !== exp_rep.drop) begin
          if (fail_count < MAX_SHOWN) begin
            $display("mismatch: expected max=%h min=%h empty=%b count=%0d dropped=%b",
                     exp_rep.max_v, exp_rep.min_v, exp_rep.empty, exp_rep.count,
                     exp_rep.drop);
            $display("          actual   max=%h min=%h empty=%b count=%0d dropped=%b",
                     max_value, min_value, is_empty, entry_count, dropped);
          end
          fail_count++;
        end
      end
    end
  end

  // Watchdog. It ends a hung run with the fail message.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    // Directed table. The opening rows check removals and the unused code on
    // an empty store, then the two extremes of the value range, with the
    // results typed in. The middle rows build a store with duplicates and
    // both extremes, and then take it apart from both ends until it is
    // empty. Some removal operands are nonzero so that the block has to
    // ignore them.
    directed_row_t directed_rows [DIRECTED_ROWS] = '{
      '{OP_REMOVE_MAX, 32'shffffffff, 1'b1, '{32'sh0, 32'sh0, 1'b1, 7'd0, 1'b0}},
      '{OP_REMOVE_MIN, 32'sh12345678, 1'b1, '{32'sh0, 32'sh0, 1'b1, 7'd0, 1'b0}},
      '{OP_UNUSED,     32'sh7fffffff, 1'b1, '{32'sh0, 32'sh0, 1'b1, 7'd0, 1'b0}},
      '{OP_INSERT,     32'sh7fffffff, 1'b1,
        '{32'sh7fffffff, 32'sh7fffffff, 1'b0, 7'd1, 1'b0}},
      '{OP_INSERT,     32'sh80000000, 1'b1,
        '{32'sh7fffffff, 32'sh80000000, 1'b0, 7'd2, 1'b0}},
      '{OP_INSERT,     32'sh00000000, 1'b0, '{32'sh0, 32'sh0, 1'b0, 7'd0, 1'b0}},
      '{OP_INSERT,     32'shffffffff, 1'b0, '{32'sh0, 32'sh0, 1'b0, 7'd0, 1'b0}},
      '{OP_INSERT,     32'shffffffff, 1'b0, '{32'sh0, 32'sh0, 1'b0, 7'd0, 1'b0}},
      '{OP_INSERT,     32'sh00000001, 1'b0, '{32'sh0, 32'sh0, 1'b0, 7'd0, 1'b0}},
      '{OP_UNUSED,     32'sh55555555, 1'b0, '{32'sh0, 32'sh0, 1'b0, 7'd0, 1'b0}},
      '{OP_REMOVE_MAX, 32'shaaaaaaaa, 1'b0, '{32'sh0, 32'sh0, 1'b0, 7'd0, 1'b0}},
      '{OP_REMOVE_MIN, 32'sh0, 1'b0, '{32'sh0, 32'sh0, 1'b0, 7'd0, 1'b0}},
      '{OP_REMOVE_MIN, 32'sh0, 1'b0, '{32'sh0, 32'sh0, 1'b0, 7'd0, 1'b0}},
      '{OP_INSERT,     32'sh80000000, 1'b0, '{32'sh0, 32'sh0, 1'b0, 7'd0, 1'b0}},
      '{OP_REMOVE_MAX, 32'sh0, 1'b0, '{32'sh0, 32'sh0, 1'b0, 7'd0, 1'b0}},
      '{OP_REMOVE_MAX, 32'sh0, 1'b0, '{32'sh0, 32'sh0, 1'b0, 7'd0, 1'b0}},
      '{OP_REMOVE_MIN, 32'sh0, 1'b0, '{32'sh0, 32'sh0, 1'b0, 7'd0, 1'b0}},
      '{OP_REMOVE_MIN, 32'sh0, 1'b0, '{32'sh0, 32'sh0, 1'b0, 7'd0, 1'b0}},
      '{OP_REMOVE_MIN, 32'sh55aa55aa, 1'b1, '{32'sh0, 32'sh0, 1'b1, 7'd0, 1'b0}},
      '{OP_INSERT,     32'sh5555aaaa, 1'b0, '{32'sh0, 32'sh0, 1'b0, 7'd0, 1'b0}}
    };
    // Alternating fill and drain runs push the store past capacity twice,
    // which exercises the refused insert. They also take it back down to
    // removals on an empty store.
    run_kind_t run_plan [RUN_COUNT] = '{MIX_RUN, FILL_RUN, FILL_RUN, DRAIN_RUN, DRAIN_RUN,
                                        MIX_RUN, FILL_RUN, FILL_RUN, DRAIN_RUN, DRAIN_RUN};
    queue_report_t no_report;
    int insert_pct;
    int settle;

    no_report = '{32'sh0, 32'sh0, 1'b0, 7'd0, 1'b0};

    // Every input is known from time zero. Reset is asserted only once.
    rst       = 1'b1;
    start     = 1'b0;
    operation = OP_INSERT;
    value     = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // The sender idles lightly during the directed part and the first
    // random runs, heavily in the middle runs, and not at all in the last
    // runs, where beats go back to back.
    idle_pct = 9;
    foreach (directed_rows[i])
      issue_command(directed_rows[i].code, directed_rows[i].operand,
                    directed_rows[i].typed, directed_rows[i].report);

    for (int r = 0; r < RUN_COUNT; r++) begin
      idle_pct = (r < 4) ? 9 : (r < 7) ? 46 : 0;
      case (run_plan[r])
        FILL_RUN:  insert_pct = 92;
        DRAIN_RUN: insert_pct = 10;
        default:   insert_pct = 48;
      endcase
      repeat (RUN_LEN) issue_command(pick_code(insert_pct), pick_operand(), 1'b0, no_report);
    end

    @(negedge clk);
    start <= 1'b0;

    // Wait until every awaited beat has arrived; the watchdog bounds this.
    // Then keep watching for stray strobes over the drain period.
    while (awaited_reports.size() != 0) @(posedge clk);
    for (settle = 0; settle < DRAIN_CYCLES; settle++) @(posedge clk);

    if (fail_count == 0 && awaited_reports.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
